// ----- design/lru_pkg.sv -----
// Package for the LRU cache with expiry: command codes, register indexes and widths.
// No dependencies.
package lru_pkg;
    localparam int TIME_BITS = 48;
    localparam int CMD_BITS = 3;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 32;
    localparam int STAT_BITS = 32;

    localparam logic [CMD_BITS-1:0] CMD_PUT = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_GET = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_REMOVE = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_TICK = 3'd4;
    localparam logic [CMD_BITS-1:0] CMD_STATCLR = 3'd5;

    localparam logic [CFG_IDX_BITS-1:0] REG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_TTL_EN = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_DEF_TTL = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_STATS_EN = 2'd3;

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    typedef logic [STAT_BITS-1:0] t_stat;
endpackage

// ----- design/lru_cache_with_ttl.sv -----
// Top level of the fully associative LRU key/value cache with per-entry expiry.
// Depends on lru_pkg.
//
// Usage: commands arrive on the input channel (i_valid/o_ready) with a command
// code, key, value and ttl. Each item gives exactly one result on the output
// channel (o_valid/i_ready): a success flag, the read value, the entry count
// and the six statistics counters after the command.
// All slots are compared in parallel and ranks update in parallel in the
// cycle an item is accepted; the result is registered, and an item can be taken
// every cycle while the receiver takes each result (one per cycle sustained).
// The rate is set by the single-pass key compare and rank update.
// The output register is the only buffer: while a result waits, a new item is
// accepted only if the result is taken in the same cycle; a stalled receiver
// therefore holds the block.
// Reset empties the cache, zeroes time and counters and restores the
// register defaults (capacity 16, expiry and statistics off).
// Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect at once;
// the user must make them only while the block is idle (not enforced by the block).
module lru_cache_with_ttl
    import lru_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 32,
    parameter int DATA_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [CMD_BITS-1:0]      i_command,
    input  logic [31:0]              i_lookup_key,
    input  logic [31:0]              i_new_value,
    input  logic [31:0]              i_ttl_ms,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic                     o_success,
    output logic [31:0]              o_read_value,
    output logic [4:0]               o_entry_count,
    output logic [31:0]              o_gets_total,
    output logic [31:0]              o_hits_total,
    output logic [31:0]              o_misses_total,
    output logic [31:0]              o_puts_total,
    output logic [31:0]              o_evictions_total,
    output logic [31:0]              o_expirations_total
);
    localparam int RB = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CB = $clog2(CAPACITY + 1);
    localparam int SB = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [CAPACITY-1:0]  r_valid, n_valid;
    logic [KEY_BITS-1:0]  r_key   [CAPACITY];
    logic [DATA_BITS-1:0] r_data  [CAPACITY];
    logic [TIME_BITS-1:0] r_exp   [CAPACITY];
    logic [RB-1:0]        r_rank  [CAPACITY];
    logic [RB-1:0]        n_rank  [CAPACITY];
    logic [CB-1:0]        r_count, n_count;
    logic [TIME_BITS-1:0] r_now;
    t_stat                r_st [6];
    t_stat                n_st [6];

    logic [4:0]  r_cap_cfg;
    logic        r_ttl_en, r_stats_en;
    logic [31:0] r_def_ttl;

    logic        r_out_valid, r_ok;
    logic [31:0] r_rd;

    logic                 acc;
    logic [KEY_BITS-1:0]  key;
    logic [DATA_BITS-1:0] dat;
    logic [CAPACITY-1:0]  hit_vec, free_vec, lru_vec;
    logic                 hit, free_any, lru_any;
    logic [SB-1:0]        hit_idx, free_idx, lru_idx;
    logic [CB-1:0]        cap;
    logic [31:0]          ttl_eff;
    logic [TIME_BITS:0]   exp_sum;
    logic [TIME_BITS-1:0] exp_new;
    logic                 expired;
    logic                 wr_slot;
    logic [SB-1:0]        wr_idx;
    logic                 ok;
    logic [31:0]          rd;
    logic                 evict;

    assign acc = i_valid && o_ready;
    assign o_ready = !r_out_valid || i_ready;
    assign key = KEY_BITS'(i_lookup_key);
    assign dat = DATA_BITS'(i_new_value);

    always_comb begin
        hit_idx = '0;
        free_idx = '0;
        lru_idx = '0;
        hit = 1'b0;
        free_any = 1'b0;
        lru_any = 1'b0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            hit_vec[i] = r_valid[i] && (r_key[i] == key);
            free_vec[i] = !r_valid[i];
            lru_vec[i] = r_valid[i] && (CB'(r_rank[i]) == r_count - CB'(1));
            if (hit_vec[i]) begin
                hit = 1'b1;
                hit_idx = SB'(i);
            end
            if (free_vec[i]) begin
                free_any = 1'b1;
                free_idx = SB'(i);
            end
            if (lru_vec[i]) begin
                lru_any = 1'b1;
                lru_idx = SB'(i);
            end
        end
    end

    always_comb begin
        if (r_cap_cfg == 5'd0) begin
            cap = CB'(1);
        end else if (32'(r_cap_cfg) > 32'(CAPACITY)) begin
            cap = CB'(CAPACITY);
        end else begin
            cap = CB'(r_cap_cfg);
        end
        ttl_eff = (i_ttl_ms != 32'd0) ? i_ttl_ms : r_def_ttl;
        exp_sum = {1'b0, r_now} + (TIME_BITS + 1)'(ttl_eff);
        if (!r_ttl_en || ttl_eff == 32'd0 || exp_sum[TIME_BITS]) begin
            exp_new = TIME_MAX;
        end else begin
            exp_new = exp_sum[TIME_BITS-1:0];
        end
        expired = r_ttl_en && (r_now > r_exp[hit_idx]);
    end

    always_comb begin
        logic [RB-1:0] rr;
        logic          drop;
        logic          freed;
        logic [SB-1:0] fi;
        n_valid = r_valid;
        n_rank = r_rank;
        n_count = r_count;
        n_st = r_st;
        ok = 1'b0;
        rd = '0;
        wr_slot = 1'b0;
        wr_idx = '0;
        evict = 1'b0;
        rr = r_rank[hit_idx];
        drop = 1'b0;
        freed = free_any;
        fi = free_idx;
        case (i_command)
            CMD_PUT: begin
                ok = 1'b1;
                if (r_stats_en) n_st[3] = r_st[3] + 1'b1;
                if (hit) begin
                    for (int i = 0; i < CAPACITY; i++)
                        if (r_valid[i] && r_rank[i] < rr) n_rank[i] = r_rank[i] + 1'b1;
                    n_rank[hit_idx] = '0;
                    wr_slot = 1'b1;
                    wr_idx = hit_idx;
                end else begin
                    if (r_count >= cap && r_count != '0 && lru_any) begin
                        evict = 1'b1;
                        if (r_stats_en) n_st[4] = r_st[4] + 1'b1;
                        // The evicted slot is freed; the LRU entry leaves and all
                        // others age by one, so the net effect is a plain shift.
                        if (!free_any) begin
                            freed = 1'b1;
                            fi = lru_idx;
                        end
                    end
                    if (freed) begin
                        for (int i = 0; i < CAPACITY; i++)
                            if (r_valid[i]) n_rank[i] = r_rank[i] + 1'b1;
                        if (evict) n_valid[lru_idx] = 1'b0;
                        if (evict) n_rank[lru_idx] = '0;
                        n_valid[fi] = 1'b1;
                        n_rank[fi] = '0;
                        n_count = evict ? r_count : r_count + 1'b1;
                        wr_slot = 1'b1;
                        wr_idx = fi;
                    end else if (evict) begin
                        n_valid[lru_idx] = 1'b0;
                        n_rank[lru_idx] = '0;
                        n_count = r_count - 1'b1;
                    end
                end
            end
            CMD_GET: begin
                if (r_stats_en) n_st[0] = r_st[0] + 1'b1;
                if (!hit) begin
                    if (r_stats_en) n_st[2] = r_st[2] + 1'b1;
                end else if (expired) begin
                    drop = 1'b1;
                    if (r_stats_en) n_st[2] = r_st[2] + 1'b1;
                    if (r_stats_en) n_st[5] = r_st[5] + 1'b1;
                end else begin
                    for (int i = 0; i < CAPACITY; i++)
                        if (r_valid[i] && r_rank[i] < rr) n_rank[i] = r_rank[i] + 1'b1;
                    n_rank[hit_idx] = '0;
                    if (r_stats_en) n_st[1] = r_st[1] + 1'b1;
                    rd = 32'(r_data[hit_idx]);
                    ok = 1'b1;
                end
            end
            CMD_REMOVE: begin
                drop = hit;
                ok = hit;
            end
            CMD_CLEAR: begin
                n_valid = '0;
                for (int i = 0; i < CAPACITY; i++) n_rank[i] = '0;
                n_count = '0;
                ok = 1'b1;
            end
            CMD_TICK: ok = 1'b1;
            CMD_STATCLR: begin
                for (int i = 0; i < 6; i++) n_st[i] = '0;
                ok = 1'b1;
            end
            default: ok = 1'b0;
        endcase
        if (drop) begin
            for (int i = 0; i < CAPACITY; i++)
                if (r_valid[i] && r_rank[i] > rr) n_rank[i] = r_rank[i] - 1'b1;
            n_valid[hit_idx] = 1'b0;
            n_rank[hit_idx] = '0;
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int i = 0; i < CAPACITY; i++) r_rank[i] <= '0;
            r_count <= '0;
            r_now <= '0;
            for (int i = 0; i < 6; i++) r_st[i] <= '0;
            r_cap_cfg <= 5'd16;
            r_ttl_en <= 1'b0;
            r_def_ttl <= '0;
            r_stats_en <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_CAPACITY: r_cap_cfg <= i_cfg_data[4:0];
                    REG_TTL_EN:   r_ttl_en <= i_cfg_data[0];
                    REG_DEF_TTL:  r_def_ttl <= i_cfg_data;
                    REG_STATS_EN: r_stats_en <= i_cfg_data[0];
                    default:      r_stats_en <= r_stats_en;
                endcase
            end
            if (acc) begin
                r_valid <= n_valid;
                r_rank <= n_rank;
                r_count <= n_count;
                r_st <= n_st;
                if (i_command == CMD_TICK && r_now != TIME_MAX) r_now <= r_now + 1'b1;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_ok <= ok;
            r_rd <= rd;
            if (wr_slot) begin
                if (!hit) r_key[wr_idx] <= key;
                r_data[wr_idx] <= dat;
                r_exp[wr_idx] <= exp_new;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_success = r_ok;
    assign o_read_value = r_rd;
    assign o_entry_count = 5'(r_count);
    assign o_gets_total = r_st[0];
    assign o_hits_total = r_st[1];
    assign o_misses_total = r_st[2];
    assign o_puts_total = r_st[3];
    assign o_evictions_total = r_st[4];
    assign o_expirations_total = r_st[5];
endmodule

// ----- design/lru_checker.sv -----
// Port-level checker for the LRU cache, bound to the top level.
// Depends on lru_pkg.
module lru_checker
    import lru_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  i_command,
    input logic [4:0]  o_entry_count,
    input logic        o_success,
    input logic [31:0] o_read_value
);
    // An item accepted gives a result in the next cycle.
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> o_valid) else $error("missing result");
    // A waiting result is never overwritten.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready) else $error("result overrun");
    // A clear leaves the cache empty.
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_command == CMD_CLEAR |=> o_entry_count == 5'd0 && o_success)
        else $error("clear not empty");
    // Any failed command returns zero data.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_success |-> o_read_value == 32'd0) else $error("data on miss");
endmodule

bind lru_cache_with_ttl lru_checker u_lru_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .i_command(i_command),
    .o_entry_count(o_entry_count), .o_success(o_success), .o_read_value(o_read_value)
);
